// File: design/kmer_frequency_counter_core_macros.svh
// Assertion macros for the k-mer frequency counter core.
// Each macro expects a clock named clk and a reset named rst in the scope of use.
`ifndef KMER_FREQUENCY_COUNTER_CORE_MACROS_SVH
`define KMER_FREQUENCY_COUNTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KFC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kfc assertion failed");

// Next-cycle implication, checked outside reset.
`define KFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kfc assertion failed");

`endif

// File: design/kfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the k-mer frequency counter core.
// No dependencies; imported by the core.
package kfc_pkg;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [2:0] WORD_LENGTH_RESET = 3'd6;

  typedef enum logic {
    OP_INC,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  base;
    logic [11:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] count;
    logic        saturated;
  } out_item_t;

endpackage

// File: design/kfc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module kfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/kmer_frequency_counter_core.sv
`timescale 1ns / 1ps
// K-mer frequency counter: one item per cycle while in_ready is high, histogram kept
// in a single RAM. A read item's result goes through stage 1 into the result buffer;
// base and start items give no result. The histogram read-modify-write spans stage 0
// and stage 1; the registered RAM read sets the forwarding window to a single entry.
// After reset a clearing pass writes zero to all 4^MAX_WORD_LENGTH bins (4096 by
// default), one per cycle, with in_ready low; configuration writes still go in.
`include "kmer_frequency_counter_core_macros.svh"

module kmer_frequency_counter_core #(
  parameter int MAX_WORD_LENGTH = 6,
  parameter int COUNT_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  kfc_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output kfc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data
);

  import kfc_pkg::*;

  localparam int WIN_BITS = 2 * MAX_WORD_LENGTH;
  localparam int DEPTH    = 1 << WIN_BITS;
  localparam int RUN_BITS = $clog2(MAX_WORD_LENGTH + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration and sequence state.
  logic [2:0]          word_length;
  logic [WIN_BITS-1:0] window, window_next;
  logic [RUN_BITS-1:0] valid_run, valid_run_next;

  // Clearing pass.
  logic                clearing;
  logic [WIN_BITS-1:0] clr_addr;

  // Stage 1 of the read-modify-write.
  logic                s1_valid;
  op_t                 s1_op;
  logic [WIN_BITS-1:0] s1_addr;

  // Last write, forwarded to a read of the same bin issued in the same cycle.
  logic                  fwd_valid;
  logic [WIN_BITS-1:0]   fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;

  // Result buffer, two entries.
  out_item_t  fifo_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fifo_cnt;

  logic                  accept;
  logic                  rd_en;
  op_t                   rd_op;
  logic [WIN_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] ram_rdata, old_count, new_count;
  logic                  mem_we;
  logic [WIN_BITS-1:0]   mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  push, pop;
  logic [RUN_BITS-1:0]   k_eff;
  logic [WIN_BITS-1:0]   word_mask;
  logic [WIN_BITS+11:0]  idx_ext;
  logic [COUNT_BITS+15:0] count_ext;
  out_item_t             result;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid & in_ready;

  // Effective word length: zero acts as one, anything past the maximum is clamped.
  always_comb begin
    if (word_length == 3'd0) begin
      k_eff = RUN_BITS'(1);
    end else if ({1'b0, word_length} > 4'(MAX_WORD_LENGTH)) begin
      k_eff = RUN_BITS'(MAX_WORD_LENGTH);
    end else begin
      k_eff = RUN_BITS'(word_length);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WORD_LENGTH; i++) begin
      word_mask[2*i +: 2] = (RUN_BITS'(i) < k_eff) ? 2'b11 : 2'b00;
    end
  end

  assign idx_ext = {{WIN_BITS{1'b0}}, in_data.bin_index};

  // Stage 0: update the window and run, pick the bin to touch.
  always_comb begin
    window_next    = window;
    valid_run_next = valid_run;
    rd_en          = 1'b0;
    rd_op          = OP_INC;
    rd_addr        = idx_ext[WIN_BITS-1:0];
    if (accept) begin
      case (in_data.cmd)
        CMD_PUSH: begin
          if (in_data.base[2]) begin
            valid_run_next = '0;
          end else begin
            window_next = (window << 2) | WIN_BITS'(in_data.base[1:0]);
            if (valid_run < RUN_BITS'(MAX_WORD_LENGTH)) begin
              valid_run_next = valid_run + RUN_BITS'(1);
            end
            rd_addr = window_next & word_mask;
            rd_en   = (valid_run_next >= k_eff);
          end
        end
        CMD_READ: begin
          rd_en = 1'b1;
          rd_op = OP_READ;
        end
        CMD_START: begin
          valid_run_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= WORD_LENGTH_RESET;
      window      <= '0;
      valid_run   <= '0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      s1_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        word_length <= cfg_data;
      end
      window    <= window_next;
      valid_run <= valid_run_next;
      if (clearing) begin
        clr_addr <= clr_addr + WIN_BITS'(1);
        if (clr_addr == {WIN_BITS{1'b1}}) begin
          clearing <= 1'b0;
        end
      end
      s1_valid  <= rd_en;
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_op   <= rd_op;
      s1_addr <= rd_addr;
    end
    fwd_addr <= s1_addr;
    fwd_data <= new_count;
  end

  kfc_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  // Stage 1: modify and write back.
  always_comb begin
    old_count = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : ram_rdata;
    if (s1_op == OP_READ) begin
      new_count = '0;
    end else if (old_count == COUNT_MAX) begin
      new_count = old_count;
    end else begin
      new_count = old_count + COUNT_BITS'(1);
    end
  end

  assign mem_we    = clearing | s1_valid;
  assign mem_waddr = clearing ? clr_addr : s1_addr;
  assign mem_wdata = clearing ? '0 : new_count;

  assign count_ext        = {16'd0, old_count};
  assign result.count     = count_ext[15:0];
  assign result.saturated = (old_count == COUNT_MAX);

  // Result buffer; in_ready leaves room for the item in stage 1 and the new one.
  assign push      = s1_valid & (s1_op == OP_READ);
  assign pop       = out_valid & out_ready;
  assign out_valid = (fifo_cnt != 2'd0);
  assign out_data  = fifo_mem[rd_ptr];
  assign in_ready  = ~clearing &
                     ((3'(fifo_cnt) + 3'(push)) <= (3'd1 + 3'(pop)));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= result;
    end
  end

  `KFC_ASSERT_NOW(a_no_accept_while_clearing, clearing, !in_ready && !s1_valid)
  `KFC_ASSERT_NOW(a_fifo_bound, 1'b1, fifo_cnt <= 2'd2)
  `KFC_ASSERT_NEXT(a_read_enters_s1, accept && in_data.cmd == CMD_READ, s1_valid && s1_op == OP_READ)
  `KFC_ASSERT_NEXT(a_no_overflow, push && !pop && fifo_cnt == 2'd2, 1'b0)

endmodule

// File: tb/kmer_frequency_counter_checker.sv
`timescale 1ns / 1ps
// Checker for the k-mer frequency counter core: tracks the word histogram from
// the accepted items and compares every read result. Depends on kfc_pkg.
module kmer_frequency_counter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  kfc_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  kfc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_data,
  output int                 mismatches,
  output int                 reads_pending
);

  import kfc_pkg::*;

  localparam int          MAX_K     = 6;
  localparam int          NUM_BINS  = 4096;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  logic [2:0]  word_len;
  logic [11:0] base_window;
  logic [2:0]  run_len;
  logic [15:0] bin_counts [NUM_BINS];
  out_item_t   pending_counts [$];

  function automatic int unsigned active_word_len(logic [2:0] k);
    if (k == 3'd0) return 1;
    if (k > MAX_K) return MAX_K;
    return 32'(k);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic count_base(input logic [2:0] b);
    int unsigned k;
    logic [11:0] bin;
    // Codes above T break the run just like N does.
    if (b > 3'd3) begin
      run_len = 3'd0;
      return;
    end
    base_window = {base_window[9:0], b[1:0]};
    if (run_len < MAX_K) run_len++;
    k = active_word_len(word_len);
    if (run_len >= k) begin
      bin = 12'(32'(base_window) & ((32'd1 << (2 * k)) - 32'd1));
      if (bin_counts[bin] != COUNT_MAX) bin_counts[bin]++;
    end
  endtask

  task automatic read_bin(input logic [11:0] idx);
    out_item_t res;
    res.count     = bin_counts[idx];
    res.saturated = (bin_counts[idx] == COUNT_MAX);
    bin_counts[idx] = '0;
    pending_counts.insert(pending_counts.size(), res);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      word_len    = WORD_LENGTH_RESET;
      base_window = '0;
      run_len     = '0;
      mismatches  = 0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      pending_counts.delete();
    end else begin
      if (cfg_valid && cfg_ready) word_len = cfg_data;
      if (in_valid && in_ready) begin
        case (in_data.cmd)
          CMD_PUSH:  count_base(in_data.base);
          CMD_READ:  read_bin(in_data.bin_index);
          CMD_START: run_len = 3'd0;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_counts.size() == 0) begin
          report_mismatch($sformatf("unexpected result count=%0d saturated=%0b",
                                    out_data.count, out_data.saturated));
        end else begin
          want = pending_counts.pop_front();
          if (out_data.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_data.count, want.count));
          if (out_data.saturated !== want.saturated)
            report_mismatch($sformatf("saturated %0b, expected %0b",
                                      out_data.saturated, want.saturated));
        end
      end
    end
    reads_pending <= pending_counts.size();
  end

endmodule

// File: tb/kmer_frequency_counter_core_tb.sv
`timescale 1ns / 1ps
// Top-level bench for the k-mer frequency counter core: drives bases, reads and
// word-length writes. Depends on kfc_pkg, the core and the histogram checker.
module kmer_frequency_counter_core_tb;
  import kfc_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_data;

  int mismatches;
  int reads_pending;
  bit steady;
  bit squeeze;
  int cur_k;
  int pushes_sent;
  int reads_sent;
  int others_sent;

  kmer_frequency_counter_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  kmer_frequency_counter_checker hist_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .reads_pending (reads_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, one long hold-off when asked for.
  initial begin
    bit squeezed;
    squeezed  = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic send(input logic [1:0] c, input logic [2:0] b, input logic [11:0] idx);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_data.cmd       <= c;
    in_data.base      <= b;
    in_data.bin_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == CMD_PUSH) pushes_sent++;
    else if (c == CMD_READ) reads_sent++;
    else others_sent++;
  endtask

  task automatic write_word_len(input logic [2:0] k);
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_k = int'(k);
  endtask

  // Wait for every read result, then give the histogram pipeline time to drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (reads_pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item();
    int r;
    int kk;
    logic [11:0] idx;
    r  = $urandom_range(99);
    kk = (cur_k == 0) ? 1 : ((cur_k > 6) ? 6 : cur_k);
    if (r < 70) begin
      send(CMD_PUSH, 3'($urandom_range(3)), 12'($urandom));
    end else if (r < 76) begin
      send(CMD_PUSH, 3'($urandom_range(7, 4)), 12'($urandom));
    end else if (r < 90) begin
      // Half of the reads aim at bins that the current word length can fill.
      if ($urandom_range(1) == 0) idx = 12'($urandom);
      else idx = 12'($urandom_range((1 << (2 * kk)) - 1));
      send(CMD_READ, 3'($urandom), idx);
    end else if (r < 95) begin
      send(CMD_START, 3'($urandom), 12'($urandom));
    end else begin
      send(CMD_NONE, 3'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    int k_list [8];
    k_list      = '{1, 0, 2, 3, 7, 4, 5, 6};
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    steady      = 1'b0;
    squeeze     = 1'b0;
    pushes_sent = 0;
    reads_sent  = 0;
    others_sent = 0;
    rst         = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: the words ACGTAC and CGTACG, then N and the codes above it.
    write_word_len(3'd6);
    send(CMD_PUSH, 3'd0, 12'h000);
    send(CMD_PUSH, 3'd1, 12'hFFF);
    send(CMD_PUSH, 3'd2, 12'h000);
    send(CMD_PUSH, 3'd3, 12'hFFF);
    send(CMD_PUSH, 3'd0, 12'h000);
    send(CMD_PUSH, 3'd1, 12'hFFF);
    send(CMD_PUSH, 3'd2, 12'h000);
    send(CMD_PUSH, 3'd4, 12'hFFF);
    send(CMD_PUSH, 3'd3, 12'h000);
    send(CMD_PUSH, 3'd5, 12'hFFF);
    send(CMD_PUSH, 3'd0, 12'h000);
    send(CMD_PUSH, 3'd6, 12'hFFF);
    send(CMD_PUSH, 3'd7, 12'h000);
    send(CMD_START, 3'd7, 12'hFFF);
    send(CMD_NONE, 3'd7, 12'hFFF);
    send(CMD_READ, 3'd0, 12'h1B1);
    send(CMD_READ, 3'd7, 12'h1B1);
    send(CMD_READ, 3'd0, 12'h6C6);
    send(CMD_READ, 3'd0, 12'h000);
    send(CMD_READ, 3'd7, 12'hFFF);
    settle();

    foreach (k_list[i]) begin
      write_word_len(3'(k_list[i]));
      steady = (i == 1);
      if (i == 3) begin
        // Flood reads while the result side holds off, so the core backs up.
        squeeze = 1'b1;
        repeat (40) send(CMD_READ, 3'($urandom), 12'($urandom_range(63)));
      end
      repeat (190) random_item();
      settle();
    end

    $display("Covered %0d base pushes, %0d bin reads and %0d start or unused commands,",
             pushes_sent, reads_sent, others_sent);
    $display("over word lengths 0 to 7, a gap-free stretch and a long result stall.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/kfc_pkg.sv
design/kfc_ram.sv
design/kmer_frequency_counter_core.sv
tb/kmer_frequency_counter_checker.sv
tb/kmer_frequency_counter_core_tb.sv
